@@ hdl/diff_pair_rx_fault_qualifier_core_defines.svh @@
// assertion macros for the differential pair fault qualifier
// bodies expect clk and rst in the scope that uses them
`ifndef DIFF_PAIR_RX_FAULT_QUALIFIER_CORE_DEFINES_SVH
`define DIFF_PAIR_RX_FAULT_QUALIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define DPRFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dprfq assertion failed");

// next-cycle implication
`define DPRFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dprfq assertion failed");

`endif

@@ hdl/dprfq_pkg.sv @@
// shared widths, reset values and register indexes of the pair fault qualifier
// no dependencies
`default_nettype none

package dprfq_pkg;

  localparam int FIELD_W = 8;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [FIELD_W-1:0]   lines_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CONFIRM_SAMPLES  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ACTIVITY_TIMEOUT = cfg_idx_t'(1);

  localparam cnt_t CONFIRM_RESET = cnt_t'(6);
  localparam cnt_t TIMEOUT_RESET = cnt_t'(10);

endpackage

`default_nettype wire

@@ hdl/dprfq_ifs.sv @@
// valid/ready channels of the pair fault qualifier: samples, results, config
// depends on dprfq_pkg
`default_nettype none

interface dprfq_sample_if import dprfq_pkg::*; ();
  logic   valid;
  logic   ready;
  lines_t host_p_lines;
  lines_t host_n_lines;
  lines_t lane_p_lines;
  lines_t lane_n_lines;

  modport source (output valid, host_p_lines, host_n_lines, lane_p_lines, lane_n_lines,
                  input ready);
  modport sink   (input valid, host_p_lines, host_n_lines, lane_p_lines, lane_n_lines,
                  output ready);
endinterface

interface dprfq_result_if import dprfq_pkg::*; ();
  logic   valid;
  logic   ready;
  lines_t host_fault_mask;
  lines_t lane_fault_mask;

  modport source (output valid, host_fault_mask, lane_fault_mask, input ready);
  modport sink   (input valid, host_fault_mask, lane_fault_mask, output ready);
endinterface

interface dprfq_cfg_if import dprfq_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cnt_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/diff_pair_rx_fault_qualifier_core.sv @@
// a sample word passes through the sample register, then the result register
// throughput: one sample word per cycle while the result side takes words; the
// per-pair counter update sits between the sample register and the result register
// reset (rst, synchronous): pair state, valid flags and config back to defaults
// (confirm 6, timeout 10); config port is always ready
`default_nettype none
`include "diff_pair_rx_fault_qualifier_core_defines.svh"

module diff_pair_rx_fault_qualifier_core import dprfq_pkg::*; #(
  parameter int PAIRS_PER_GROUP = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  dprfq_sample_if.sink    sample,
  dprfq_result_if.source  result,
  dprfq_cfg_if.sink       cfg
);

  localparam int NUM_PAIRS = 2 * PAIRS_PER_GROUP;

  // configuration registers
  cnt_t confirm;
  cnt_t timeout;

  // sample register stage
  logic   s1_valid;
  lines_t s1_host_p;
  lines_t s1_host_n;
  lines_t s1_lane_p;
  lines_t s1_lane_n;

  // result register stage
  logic   res_valid;
  lines_t host_mask;
  lines_t lane_mask;

  // per-pair state, host pairs first then lane pairs
  logic [NUM_PAIRS-1:0]            last_p;
  logic [NUM_PAIRS-1:0]            seen;
  logic [NUM_PAIRS-1:0][CNT_W-1:0] stuck_q;
  logic [NUM_PAIRS-1:0][CNT_W-1:0] bad_q;
  logic [NUM_PAIRS-1:0]            fault_q;

  wire  [NUM_PAIRS-1:0]            last_p_next;
  wire  [NUM_PAIRS-1:0][CNT_W-1:0] stuck_next;
  wire  [NUM_PAIRS-1:0][CNT_W-1:0] bad_next;
  wire  [NUM_PAIRS-1:0]            fault_next;

  wire  [FIELD_W-1:0]              host_mask_next;
  wire  [FIELD_W-1:0]              lane_mask_next;

  logic advance;
  logic s1_fire;

  // the result register frees whenever it is empty or being taken
  assign advance      = !res_valid || result.ready;
  assign s1_fire      = s1_valid && advance;
  // a new word may enter while the previous result still waits
  assign sample.ready = !s1_valid || advance;

  assign result.valid           = res_valid;
  assign result.host_fault_mask = host_mask;
  assign result.lane_fault_mask = lane_mask;

  assign cfg.ready = 1'b1;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      confirm <= CONFIRM_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CONFIRM_SAMPLES:  confirm <= cfg.data;
        REG_ACTIVITY_TIMEOUT: timeout <= cfg.data;
        default: ;
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_host_p <= sample.host_p_lines;
      s1_host_n <= sample.host_n_lines;
      s1_lane_p <= sample.lane_p_lines;
      s1_lane_n <= sample.lane_n_lines;
    end
  end

  // per-pair watchdog and integrating fault counter
  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
    localparam int GRP = k / PAIRS_PER_GROUP;
    localparam int CH  = k % PAIRS_PER_GROUP;

    logic p_bit;
    logic n_bit;
    cnt_t stuck_nx;
    cnt_t bad_nx;
    logic fault_nx;
    logic pair_bad;

    // channels beyond the field width see both lines low
    if (CH < FIELD_W) begin : g_tap
      assign p_bit = (GRP == 0) ? s1_host_p[CH] : s1_lane_p[CH];
      assign n_bit = (GRP == 0) ? s1_host_n[CH] : s1_lane_n[CH];
    end else begin : g_none
      assign p_bit = 1'b0;
      assign n_bit = 1'b0;
    end

    always_comb begin
      // stuck count restarts on a toggle or on the very first sample
      stuck_nx = '0;
      if (seen[k] && (p_bit == last_p[k])) begin
        stuck_nx = (stuck_q[k] < timeout) ? stuck_q[k] + 1'b1 : stuck_q[k];
      end
      pair_bad = (p_bit == n_bit) || (stuck_nx >= timeout);

      bad_nx   = bad_q[k];
      fault_nx = fault_q[k];
      if (pair_bad) begin
        if (bad_q[k] < confirm) begin
          bad_nx = bad_q[k] + 1'b1;
        end
        if (bad_nx >= confirm) begin
          fault_nx = 1'b1;
        end
      end else if (bad_q[k] != '0) begin
        bad_nx = bad_q[k] - 1'b1;
        if (bad_nx == '0) begin
          fault_nx = 1'b0;
        end
      end
    end

    assign last_p_next[k] = p_bit;
    assign stuck_next[k]  = stuck_nx;
    assign bad_next[k]    = bad_nx;
    assign fault_next[k]  = fault_nx;
  end

  // fault masks; bits past the group size stay low
  for (genvar i = 0; i < FIELD_W; i++) begin : g_mask
    if (i < PAIRS_PER_GROUP) begin : g_used
      assign host_mask_next[i] = fault_next[i];
      assign lane_mask_next[i] = fault_next[PAIRS_PER_GROUP + i];
    end else begin : g_unused
      assign host_mask_next[i] = 1'b0;
      assign lane_mask_next[i] = 1'b0;
    end
  end

  // pair state commits as the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_p  <= '0;
      seen    <= '0;
      stuck_q <= '0;
      bad_q   <= '0;
      fault_q <= '0;
    end else if (s1_fire) begin
      last_p  <= last_p_next;
      seen    <= '1;
      stuck_q <= stuck_next;
      bad_q   <= bad_next;
      fault_q <= fault_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      host_mask <= host_mask_next;
      lane_mask <= lane_mask_next;
    end
  end

  // an empty sample stage never refuses a word
  `DPRFQ_ASSERT_NOW(a_ready_when_empty, !s1_valid, sample.ready)
  // an accepted word occupies the sample stage next cycle
  `DPRFQ_ASSERT_NEXT(a_accept_fills, sample.valid && sample.ready, s1_valid)
  // a blocked word stays in the sample stage
  `DPRFQ_ASSERT_NEXT(a_s1_holds, s1_valid && !advance, s1_valid)
  // a word leaving the sample stage always lands in the result register
  `DPRFQ_ASSERT_NEXT(a_fire_gives_result, s1_fire, res_valid)
  // fault counters move only with a word
  `DPRFQ_ASSERT_NEXT(a_counts_hold, !s1_fire, $stable(bad_q) && $stable(fault_q))

endmodule

`default_nettype wire

@@ dv/tb_diff_pair_rx_fault_qualifier_core.sv @@
// self-checking testbench for the differential pair fault qualifier core
// depends on dprfq_pkg, the dprfq interfaces and diff_pair_rx_fault_qualifier_core
`timescale 1ns / 100ps

module tb_diff_pair_rx_fault_qualifier_core;
  import dprfq_pkg::*;

  // pairs per group as built here; the predictor walks host pairs then lane pairs
  localparam int GROUP_PAIRS = 8;
  localparam int ALL_PAIRS   = 2 * GROUP_PAIRS;

  // register indexes past the end of the map; writes to them must change nothing
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  // extra wait after the last result, with margin for any stray result word
  localparam int SETTLE_CYCLES = 6;
  // far above the slowest legal run, so this only trips on a hang
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    lines_t host;
    lines_t lane;
  } fault_masks_t;

  // stimulus shapes per pair: clean toggling, frozen p, shorted p/n, pure noise
  typedef enum bit [1:0] {
    PAIR_TOGGLING,
    PAIR_FROZEN,
    PAIR_SHORTED,
    PAIR_NOISY
  } pair_mode_e;

  logic clk = 1'b0;
  logic rst;

  dprfq_sample_if sample_ch ();
  dprfq_result_if result_ch ();
  dprfq_cfg_if    cfg_ch ();

  diff_pair_rx_fault_qualifier_core #(
    .PAIRS_PER_GROUP(GROUP_PAIRS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // predictor state: own copy of the limits and of every pair's counters
  cnt_t confirm_lim;
  cnt_t timeout_lim;
  bit   prev_p   [ALL_PAIRS];
  bit   primed   [ALL_PAIRS];
  cnt_t idle_run [ALL_PAIRS];
  cnt_t bad_run  [ALL_PAIRS];
  bit   flagged  [ALL_PAIRS];

  fault_masks_t expected_masks[$];
  fault_masks_t due_masks;

  // stimulus state
  pair_mode_e line_mode [ALL_PAIRS];
  bit         drive_p   [ALL_PAIRS];
  bit         idle_on;
  int         hold_request;
  int         hold_left;
  int         stall_left;

  // run statistics
  int mismatches;
  int cycle_count;
  int n_words_sent;
  int n_results_checked;
  int n_flagged_results;
  int n_cfg_writes;

  // one pair's watchdog and integrating fault counter for one sample
  function automatic bit qualify_pair(int k, bit p, bit n);
    bit bad;
    if (primed[k] && p == prev_p[k]) begin
      // p repeated: stuck count climbs, saturating at the timeout
      if (idle_run[k] < timeout_lim) idle_run[k] = idle_run[k] + 1'b1;
    end else begin
      // first sample after reset counts as a toggle
      idle_run[k] = '0;
    end
    prev_p[k] = p;
    primed[k] = 1'b1;

    bad = (p == n) || (idle_run[k] >= timeout_lim);

    if (bad) begin
      // a limit lowered below the count stops the climb but still latches
      if (bad_run[k] < confirm_lim) bad_run[k] = bad_run[k] + 1'b1;
      if (bad_run[k] >= confirm_lim) flagged[k] = 1'b1;
    end else if (bad_run[k] != '0) begin
      // flag clears only on the way down to zero
      bad_run[k] = bad_run[k] - 1'b1;
      if (bad_run[k] == '0) flagged[k] = 1'b0;
    end
    return flagged[k];
  endfunction

  function automatic fault_masks_t predict_masks(lines_t hp, lines_t hn, lines_t lp, lines_t ln);
    fault_masks_t m;
    for (int i = 0; i < GROUP_PAIRS; i++) m.host[i] = qualify_pair(i, hp[i], hn[i]);
    for (int i = 0; i < GROUP_PAIRS; i++) m.lane[i] = qualify_pair(GROUP_PAIRS + i, lp[i], ln[i]);
    return m;
  endfunction

  function automatic pair_mode_e pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return PAIR_TOGGLING;
    if (roll < 65) return PAIR_FROZEN;
    if (roll < 85) return PAIR_SHORTED;
    return PAIR_NOISY;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %02h want %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  // predictor follows every accepted register write and sample word
  always @(posedge clk) begin
    if (rst) begin
      confirm_lim = CONFIRM_RESET;
      timeout_lim = TIMEOUT_RESET;
      for (int k = 0; k < ALL_PAIRS; k++) begin
        prev_p[k]   = 1'b0;
        primed[k]   = 1'b0;
        idle_run[k] = '0;
        bad_run[k]  = '0;
        flagged[k]  = 1'b0;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_cfg_writes++;
        case (cfg_ch.index)
          REG_CONFIRM_SAMPLES:  confirm_lim = cfg_ch.data;
          REG_ACTIVITY_TIMEOUT: timeout_lim = cfg_ch.data;
          default: ;  // unmapped index, ignored by the block
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        n_words_sent++;
        expected_masks.push_back(predict_masks(sample_ch.host_p_lines, sample_ch.host_n_lines,
                                               sample_ch.lane_p_lines, sample_ch.lane_n_lines));
      end
    end
  end

  // result checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_masks.size() == 0) begin
        report_mismatch("result word with nothing pending",
                        int'({result_ch.host_fault_mask, result_ch.lane_fault_mask}), 0);
      end else begin
        due_masks = expected_masks.pop_front();
        n_results_checked++;
        if (result_ch.host_fault_mask != 8'h00 || result_ch.lane_fault_mask != 8'h00)
          n_flagged_results++;
        if (result_ch.host_fault_mask !== due_masks.host)
          report_mismatch("host_fault_mask", int'(result_ch.host_fault_mask),
                          int'(due_masks.host));
        if (result_ch.lane_fault_mask !== due_masks.lane)
          report_mismatch("lane_fault_mask", int'(result_ch.lane_fault_mask),
                          int'(due_masks.lane));
      end
    end
  end

  // result receiver: random stall bursts, plus a long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        // stall burst of random length, this one included
        stall_left = $urandom_range(1, 13) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on the whole run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_masks.size());
    $display("CHECK FAILED");
    $finish;
  end

  // offers one sample word and returns at the edge that takes it;
  // valid stays high so back-to-back words need no second assignment
  task automatic send_word(input lines_t hp, input lines_t hn, input lines_t lp, input lines_t ln);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.host_p_lines <= hp;
    sample_ch.host_n_lines <= hn;
    sample_ch.lane_p_lines <= lp;
    sample_ch.lane_n_lines <= ln;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // sender stops and waits until every predicted result word has come back
  task automatic wait_results_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cnt_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // both limits, optionally with stray writes to the unmapped indexes
  task automatic apply_config(input cnt_t confirm, input cnt_t timeout, input bit with_spares);
    write_reg(REG_CONFIRM_SAMPLES, confirm);
    if (with_spares) write_reg(REG_SPARE_A, cnt_t'($urandom));
    write_reg(REG_ACTIVITY_TIMEOUT, timeout);
    if (with_spares) write_reg(REG_SPARE_B, cnt_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // shaped pair traffic: each pair follows a mode that changes now and then,
  // so flags get a chance to latch and to clear again
  task automatic send_pair_traffic(input int words);
    logic [ALL_PAIRS-1:0] p_all;
    logic [ALL_PAIRS-1:0] n_all;
    bit p;
    bit n;
    repeat (words) begin
      for (int k = 0; k < ALL_PAIRS; k++) begin
        if ($urandom_range(0, 29) == 0) line_mode[k] = pick_mode();
        case (line_mode[k])
          PAIR_TOGGLING: begin
            p = ~drive_p[k];
            // odd glitch where n follows p
            n = ($urandom_range(0, 19) == 0) ? p : ~p;
          end
          PAIR_FROZEN: begin
            p = drive_p[k];
            n = ~p;
          end
          PAIR_SHORTED: begin
            p = bit'($urandom_range(0, 1));
            n = p;
          end
          default: begin
            p = bit'($urandom_range(0, 1));
            n = bit'($urandom_range(0, 1));
          end
        endcase
        drive_p[k] = p;
        p_all[k]   = p;
        n_all[k]   = n;
      end
      send_word(p_all[GROUP_PAIRS-1:0], n_all[GROUP_PAIRS-1:0],
                p_all[ALL_PAIRS-1:GROUP_PAIRS], n_all[ALL_PAIRS-1:GROUP_PAIRS]);
    end
  endtask

  // reset limits: all-zero, all-one and alternating lines, good and shorted
  task automatic test_line_extremes();
    send_word(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_word(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'hAA, 8'h55, 8'h55, 8'hAA);
    send_word(8'h55, 8'hAA, 8'hAA, 8'h55);
  endtask

  // confirm limit of zero: one bad sample latches and nothing clears it
  task automatic test_confirm_zero();
    wait_results_drained();
    apply_config(cnt_t'(0), TIMEOUT_RESET, 1'b0);
    send_word(8'h00, 8'h00, 8'hFF, 8'hFF);
    send_word(8'hFF, 8'h00, 8'h00, 8'hFF);
    send_word(8'h00, 8'hFF, 8'hFF, 8'h00);
  endtask

  // timeout of zero: even cleanly toggling pairs count as stuck
  task automatic test_timeout_zero();
    wait_results_drained();
    apply_config(cnt_t'(2), cnt_t'(0), 1'b0);
    send_word(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_word(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_word(8'hAA, 8'h55, 8'hAA, 8'h55);
  endtask

  // limits at the top, then confirm lowered under the running counts;
  // unmapped register indexes are written on the way
  task automatic test_limit_lowered();
    wait_results_drained();
    apply_config(cnt_t'(15), cnt_t'(15), 1'b1);
    send_word(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'h00, 8'h00, 8'h00, 8'h00);
    wait_results_drained();
    apply_config(cnt_t'(1), cnt_t'(15), 1'b1);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_word(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_word(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_word(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_word(8'h00, 8'hFF, 8'h00, 8'hFF);
  endtask

  // random traffic over a run of settings: extremes first, then random ones
  task automatic test_random_phases();
    int fixed_confirm [6] = '{1, 15, 1, 15, 0, 4};
    int fixed_timeout [6] = '{1, 15, 15, 1, 5, 0};
    cnt_t confirm;
    cnt_t timeout;
    idle_on = 1'b1;
    for (int ph = 0; ph < 12; ph++) begin
      wait_results_drained();
      if (ph < 6) begin
        confirm = cnt_t'(fixed_confirm[ph]);
        timeout = cnt_t'(fixed_timeout[ph]);
      end else begin
        confirm = cnt_t'($urandom_range(0, 15));
        timeout = cnt_t'($urandom_range(0, 15));
      end
      apply_config(confirm, timeout, bit'($urandom_range(0, 1)));
      for (int k = 0; k < ALL_PAIRS; k++) line_mode[k] = pick_mode();
      send_pair_traffic(150);
    end
  endtask

  // receiver holds off for a long stretch while words keep coming, so the
  // block fills and stalls its input; then the sender waits for a full drain
  task automatic test_backpressure();
    wait_results_drained();
    apply_config(CONFIRM_RESET, TIMEOUT_RESET, 1'b0);
    idle_on      = 1'b0;
    hold_request = 80;
    send_pair_traffic(30);
    wait_results_drained();
    idle_on = 1'b1;
    send_pair_traffic(20);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_steady_stream();
    wait_results_drained();
    apply_config(cnt_t'($urandom_range(1, 15)), cnt_t'($urandom_range(1, 15)), 1'b0);
    idle_on = 1'b0;
    send_pair_traffic(200);
  endtask

  initial begin
    mismatches        = 0;
    n_words_sent      = 0;
    n_results_checked = 0;
    n_flagged_results = 0;
    n_cfg_writes      = 0;
    hold_request      = 0;
    hold_left         = 0;
    stall_left        = 0;
    idle_on           = 1'b1;
    for (int k = 0; k < ALL_PAIRS; k++) begin
      line_mode[k] = PAIR_TOGGLING;
      drive_p[k]   = 1'b0;
    end

    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.host_p_lines <= '0;
    sample_ch.host_n_lines <= '0;
    sample_ch.lane_p_lines <= '0;
    sample_ch.lane_n_lines <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= REG_CONFIRM_SAMPLES;
    cfg_ch.data            <= '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_line_extremes();
    test_confirm_zero();
    test_timeout_zero();
    test_limit_lowered();
    test_random_phases();
    test_backpressure();
    test_steady_stream();

    // last words out, then the pipeline is given time to show any stray result
    wait_results_drained();
    if (expected_masks.size() != 0)
      report_mismatch("result words never returned", expected_masks.size(), 0);

    $display("covered %0d sample words and %0d register writes over 18 limit settings",
             n_words_sent, n_cfg_writes);
    $display("%0d result words checked, %0d carried fault flags, %0d mismatches, %0d cycles",
             n_results_checked, n_flagged_results, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dprfq_pkg.sv
hdl/dprfq_ifs.sv
hdl/diff_pair_rx_fault_qualifier_core.sv
dv/tb_diff_pair_rx_fault_qualifier_core.sv
